@@ hdl/sxt_pkg.sv @@
// Package for the s-expression tokenizer: request and result types, token,
// error and character codes, and the small classification helpers.
// No dependencies.
package sxt_pkg;

  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int SLOTS       = 4;
  localparam int SLOT_CNT_BITS = $clog2(SLOTS + 1);
  localparam int SLOT_IDX_BITS = $clog2(SLOTS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       end_of_source;
    logic [7:0] source_byte;
  } src_t;

  typedef struct packed {
    logic [1:0]             result_kind;
    logic [3:0]             token_type;
    logic [7:0]             value_byte;
    logic [2:0]             error_code;
    logic [LINE_BITS-1:0]   line_number;
    logic [COLUMN_BITS-1:0] column_number;
    logic                   last_result;
  } res_t;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_DOLLAR, MODE_COMMENT, MODE_STRING,
    MODE_ESCAPE, MODE_NUMBER, MODE_IDENT
  } mode_t;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] TOK_END       = 4'd0;
  localparam logic [3:0] TOK_DPAREN    = 4'd1;
  localparam logic [3:0] TOK_OPEN      = 4'd2;
  localparam logic [3:0] TOK_CLOSE     = 4'd3;
  localparam logic [3:0] TOK_OPEN_SQ   = 4'd4;
  localparam logic [3:0] TOK_CLOSE_SQ  = 4'd5;
  localparam logic [3:0] TOK_COMMA     = 4'd6;
  localparam logic [3:0] TOK_COLON     = 4'd7;
  localparam logic [3:0] TOK_STRING    = 4'd8;
  localparam logic [3:0] TOK_INTEGER   = 4'd9;
  localparam logic [3:0] TOK_FLOAT     = 4'd10;
  localparam logic [3:0] TOK_TRUE      = 4'd11;
  localparam logic [3:0] TOK_FALSE     = 4'd12;
  localparam logic [3:0] TOK_IDENT     = 4'd13;
  localparam logic [3:0] TOK_MALFORMED = 4'd14;

  localparam logic [2:0] ERR_NO_PAREN  = 3'd0;
  localparam logic [2:0] ERR_BAD_DOLLAR = 3'd1;
  localparam logic [2:0] ERR_UNCLOSED  = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd3;
  localparam logic [2:0] ERR_INVALID   = 3'd4;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQ     = 8'h5B;
  localparam logic [7:0] CH_RSQ     = 8'h5D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  localparam logic [3:0] KW_NONE       = 4'd0;
  localparam logic [3:0] KW_T_START    = 4'd1;
  localparam logic [3:0] KW_F_START    = 4'd5;
  localparam logic [3:0] KW_TRUE_DONE  = 4'd4;
  localparam logic [3:0] KW_FALSE_DONE = 4'd9;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] ttype;
    logic [7:0] value;
    logic [2:0] err;
  } slot_t;

  typedef struct packed {
    logic [SLOT_CNT_BITS-1:0] count;
    logic [LINE_BITS-1:0]     line;
    logic [COLUMN_BITS-1:0]   column;
    slot_t [SLOTS-1:0]        slots;
  } bundle_t;

  typedef struct packed {
    logic       emit;
    slot_t      slot;
    mode_t      mode;
    logic       clr_points;
    logic       set_kw;
    logic [3:0] kw;
    logic       newline;
    logic       col_adv;
  } idle_t;

  function automatic slot_t mk_tok(logic [3:0] t);
    slot_t s;
    s = '0;
    s.kind  = KIND_TOKEN;
    s.ttype = t;
    return s;
  endfunction

  function automatic slot_t mk_err(logic [2:0] e);
    slot_t s;
    s = '0;
    s.kind = KIND_ERROR;
    s.err  = e;
    return s;
  endfunction

  function automatic slot_t mk_val(logic [7:0] c);
    slot_t s;
    s = '0;
    s.kind  = KIND_VALUE;
    s.value = c;
    return s;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0B, 8'h0C};
  endfunction

  function automatic logic [7:0] kw_expect(logic [3:0] k);
    logic [7:0] e;
    case (k)
      4'd1:    e = 8'h72;
      4'd2:    e = 8'h75;
      4'd3:    e = 8'h65;
      4'd5:    e = 8'h61;
      4'd6:    e = 8'h6C;
      4'd7:    e = 8'h73;
      4'd8:    e = 8'h65;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  function automatic logic [3:0] number_type(logic [1:0] points);
    logic [3:0] t;
    case (points)
      2'd0:    t = TOK_INTEGER;
      2'd1:    t = TOK_FLOAT;
      default: t = TOK_MALFORMED;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] ident_type(logic [3:0] kw);
    logic [3:0] t;
    if (kw == KW_TRUE_DONE) t = TOK_TRUE;
    else if (kw == KW_FALSE_DONE) t = TOK_FALSE;
    else t = TOK_IDENT;
    return t;
  endfunction

  function automatic idle_t idle_class(logic [7:0] c);
    idle_t r;
    r = '0;
    r.mode = MODE_IDLE;
    r.col_adv = 1'b1;
    case (c)
      CH_DOLLAR: r.mode = MODE_DOLLAR;
      CH_LPAREN: begin r.emit = 1'b1; r.slot = mk_tok(TOK_OPEN); end
      CH_RPAREN: begin r.emit = 1'b1; r.slot = mk_tok(TOK_CLOSE); end
      CH_LSQ:    begin r.emit = 1'b1; r.slot = mk_tok(TOK_OPEN_SQ); end
      CH_RSQ:    begin r.emit = 1'b1; r.slot = mk_tok(TOK_CLOSE_SQ); end
      CH_COMMA:  begin r.emit = 1'b1; r.slot = mk_tok(TOK_COMMA); end
      CH_COLON:  begin r.emit = 1'b1; r.slot = mk_tok(TOK_COLON); end
      CH_SEMI:   r.mode = MODE_COMMENT;
      CH_QUOTE:  r.mode = MODE_STRING;
      default: begin
        if (is_digit(c) || c == CH_MINUS) begin
          r.emit = 1'b1;
          r.slot = mk_val(c);
          r.mode = MODE_NUMBER;
          r.clr_points = 1'b1;
        end else if (is_alpha(c)) begin
          r.emit = 1'b1;
          r.slot = mk_val(c);
          r.mode = MODE_IDENT;
          r.set_kw = 1'b1;
          r.kw = (c == CH_LOWER_T) ? KW_T_START : (c == CH_LOWER_F) ? KW_F_START : KW_NONE;
        end else if (is_space(c)) begin
          if (c == CH_NL) begin
            r.newline = 1'b1;
            r.col_adv = 1'b0;
          end
        end else begin
          r.emit = 1'b1;
          r.slot = mk_err(ERR_INVALID);
        end
      end
    endcase
    return r;
  endfunction

endpackage

@@ hdl/sxt_front.sv @@
// Front end of the tokenizer: accepts source requests, runs the lexer state
// and position counters, and forms the bundle of results for each byte.
// Depends on sxt_pkg.
module sxt_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_stall,
  input  sxt_pkg::src_t    src,
  output logic             push,
  input  logic             full,
  output sxt_pkg::bundle_t bundle
);
  import sxt_pkg::*;

  mode_t                  mode, mode_next;
  logic [1:0]             points, points_next;
  logic [3:0]             kw, kw_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [COLUMN_BITS-1:0] column, column_next;

  slot_t [SLOTS-1:0]        slots;
  logic [SLOT_CNT_BITS-1:0] n;
  logic                     accept;
  logic                     do_idle;
  logic                     col_adv;
  logic                     newline;
  logic [7:0]               c;
  idle_t                    ic;

  assign c         = src.source_byte;
  assign src_stall = full;
  assign accept    = src_valid && !full;
  assign push      = accept && (n != '0);
  assign ic        = idle_class(c);

  assign bundle.count  = n;
  assign bundle.line   = line;
  assign bundle.column = column;
  assign bundle.slots  = slots;

  always_comb begin
    slots       = '0;
    n           = '0;
    mode_next   = mode;
    points_next = points;
    kw_next     = kw;
    do_idle     = 1'b0;
    col_adv     = 1'b0;
    newline     = 1'b0;
    if (src.end_of_source) begin
      case (mode)
        MODE_DOLLAR: begin
          slots[n[SLOT_IDX_BITS-1:0]] = mk_err(ERR_NO_PAREN); n = n + 1'b1;
        end
        MODE_STRING: begin
          slots[n[SLOT_IDX_BITS-1:0]] = mk_err(ERR_UNCLOSED); n = n + 1'b1;
          slots[n[SLOT_IDX_BITS-1:0]] = mk_tok(TOK_STRING); n = n + 1'b1;
        end
        MODE_ESCAPE: begin
          slots[n[SLOT_IDX_BITS-1:0]] = mk_err(ERR_BAD_ESC); n = n + 1'b1;
          slots[n[SLOT_IDX_BITS-1:0]] = mk_err(ERR_UNCLOSED); n = n + 1'b1;
          slots[n[SLOT_IDX_BITS-1:0]] = mk_tok(TOK_STRING); n = n + 1'b1;
        end
        MODE_NUMBER: begin
          slots[n[SLOT_IDX_BITS-1:0]] = mk_tok(number_type(points)); n = n + 1'b1;
        end
        MODE_IDENT: begin
          slots[n[SLOT_IDX_BITS-1:0]] = mk_tok(ident_type(kw)); n = n + 1'b1;
        end
        default: ;
      endcase
      slots[n[SLOT_IDX_BITS-1:0]] = mk_tok(TOK_END); n = n + 1'b1;
      mode_next   = MODE_IDLE;
      points_next = '0;
      kw_next     = KW_NONE;
    end else begin
      case (mode)
        MODE_DOLLAR: begin
          slots[n[SLOT_IDX_BITS-1:0]] =
            (c == CH_LPAREN) ? mk_tok(TOK_DPAREN) : mk_err(ERR_BAD_DOLLAR);
          n = n + 1'b1;
          mode_next = MODE_IDLE;
          col_adv   = 1'b1;
        end
        MODE_COMMENT: begin
          if (c == CH_NL) do_idle = 1'b1;
          else col_adv = 1'b1;
        end
        MODE_STRING: begin
          if (c == CH_NL) begin
            slots[n[SLOT_IDX_BITS-1:0]] = mk_err(ERR_UNCLOSED); n = n + 1'b1;
            slots[n[SLOT_IDX_BITS-1:0]] = mk_tok(TOK_STRING); n = n + 1'b1;
            do_idle = 1'b1;
          end else if (c == CH_BSLASH) begin
            mode_next = MODE_ESCAPE;
            col_adv   = 1'b1;
          end else if (c == CH_QUOTE) begin
            slots[n[SLOT_IDX_BITS-1:0]] = mk_tok(TOK_STRING); n = n + 1'b1;
            mode_next = MODE_IDLE;
            col_adv   = 1'b1;
          end else begin
            slots[n[SLOT_IDX_BITS-1:0]] = mk_val(c); n = n + 1'b1;
            col_adv = 1'b1;
          end
        end
        MODE_ESCAPE: begin
          if (c == CH_NL) begin
            slots[n[SLOT_IDX_BITS-1:0]] = mk_err(ERR_BAD_ESC); n = n + 1'b1;
          end
          slots[n[SLOT_IDX_BITS-1:0]] = mk_val(c); n = n + 1'b1;
          mode_next = MODE_STRING;
          col_adv   = 1'b1;
        end
        MODE_NUMBER: begin
          if (is_digit(c) || c == CH_POINT) begin
            slots[n[SLOT_IDX_BITS-1:0]] = mk_val(c); n = n + 1'b1;
            if (c == CH_POINT && points != 2'd2) points_next = points + 2'd1;
            col_adv = 1'b1;
          end else begin
            slots[n[SLOT_IDX_BITS-1:0]] = mk_tok(number_type(points)); n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_digit(c) || is_alpha(c)) begin
            slots[n[SLOT_IDX_BITS-1:0]] = mk_val(c); n = n + 1'b1;
            kw_next = (kw_expect(kw) != 8'h00 && kw_expect(kw) == c) ? kw + 4'd1 : KW_NONE;
            col_adv = 1'b1;
          end else begin
            slots[n[SLOT_IDX_BITS-1:0]] = mk_tok(ident_type(kw)); n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        if (ic.emit) begin
          slots[n[SLOT_IDX_BITS-1:0]] = ic.slot; n = n + 1'b1;
        end
        mode_next = ic.mode;
        if (ic.clr_points) points_next = '0;
        if (ic.set_kw) kw_next = ic.kw;
        col_adv = ic.col_adv;
        newline = ic.newline;
      end
    end

    line_next   = line;
    column_next = column;
    if (src.end_of_source) begin
      line_next   = LINE_BITS'(1);
      column_next = COLUMN_BITS'(1);
    end else if (newline) begin
      if (line != '1) line_next = line + 1'b1;
      column_next = COLUMN_BITS'(1);
    end else if (col_adv) begin
      if (column != '1) column_next = column + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      points <= '0;
      kw     <= KW_NONE;
      line   <= LINE_BITS'(1);
      column <= COLUMN_BITS'(1);
    end else if (accept) begin
      mode   <= mode_next;
      points <= points_next;
      kw     <= kw_next;
      line   <= line_next;
      column <= column_next;
    end
  end

endmodule

@@ hdl/sxt_queue.sv @@
// Short register queue of result bundles between front and back end.
// Depends on sxt_pkg.
module sxt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sxt_pkg::bundle_t wr_bundle,
  output logic             full,
  output logic             head_valid,
  output sxt_pkg::bundle_t head,
  input  logic             pop
);
  import sxt_pkg::*;

  bundle_t               entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  count;
  logic                  do_push;
  logic                  do_pop;

  assign full       = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wr_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/sxt_back.sv @@
// Back end of the tokenizer: walks the head bundle one result at a time
// into the output register. Depends on sxt_pkg.
module sxt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  sxt_pkg::bundle_t head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output sxt_pkg::res_t    res
);
  import sxt_pkg::*;

  logic [SLOT_IDX_BITS-1:0] idx;
  logic                     load;
  logic                     last;
  slot_t                    cur;

  assign load = head_valid && (!res_valid || !res_stall);
  assign last = ({1'b0, idx} + 1'b1) == head.count;
  assign pop  = load && last;
  assign cur  = head.slots[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      if (load) idx <= last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.result_kind   <= cur.kind;
      res.token_type    <= cur.ttype;
      res.value_byte    <= cur.value;
      res.error_code    <= cur.err;
      res.line_number   <= head.line;
      res.column_number <= head.column;
      res.last_result   <= last;
    end
  end

endmodule

@@ hdl/s_expression_tokenizer.sv @@
// Streaming s-expression tokenizer, one source byte per request.
// Use: drive src with one byte per request and end_of_source to close the
// source. Each request yields zero to four results on res, in order: value
// bytes of strings, numbers and identifiers, completed tokens with their
// type, and error reports, all tagged with the line and column of the byte.
// last_result marks the final result of each request.
// Throughput: one request per cycle while res_stall is low and at most
// one result per request comes out; a request with several results holds
// the back end until all are out, and the four-entry bundle queue absorbs
// short bursts. Accepted bundles pass the queue, then the output register.
// src_stall rises only when the bundle queue is full. When res_stall is
// high the output register holds, the queue fills and then src stalls.
// Reset: lexer returns to idle, line and column to 1, queue and output empty.
// Depends on sxt_pkg, sxt_front, sxt_queue, sxt_back.
module s_expression_tokenizer (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  sxt_pkg::src_t src,
  output logic          res_valid,
  input  logic          res_stall,
  output sxt_pkg::res_t res
);
  import sxt_pkg::*;

  logic    push;
  logic    full;
  logic    head_valid;
  logic    pop;
  bundle_t wr_bundle;
  bundle_t head;

  sxt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src),
    .push      (push),
    .full      (full),
    .bundle    (wr_bundle)
  );

  sxt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_bundle  (wr_bundle),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  sxt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

endmodule
